// ===== rtl/stla_pkg.sv =====
// ----------------------------------------------------------------------------
// stla_pkg: shared types and constants for the session table
// Field widths, operation and event codes, register indexes and the packed
// transaction types of the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

package stla_pkg;

  // Table geometry and field widths
  localparam int SLOTS        = 16;
  localparam int KEY_BITS     = 32;
  localparam int TIME_BITS    = 48;
  localparam int LIMIT_BITS   = 32;
  localparam int CAP_BITS     = 5;
  localparam int COUNT_BITS   = 5;
  localparam int OP_BITS      = 3;
  localparam int EV_BITS      = 3;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  // Register reset values
  localparam logic [CAP_BITS-1:0]   CAPACITY_RESET = 5'd16;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = 32'd60000;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT    = 2'd1;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_ACQUIRE = 3'd0;
  localparam logic [OP_BITS-1:0] OP_LOOKUP  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_RETIRE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_EXPIRE  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_COUNT   = 3'd4;

  // Event codes
  localparam logic [EV_BITS-1:0] EV_HIT         = 3'd0;
  localparam logic [EV_BITS-1:0] EV_INSERTED    = 3'd1;
  localparam logic [EV_BITS-1:0] EV_EVICTED     = 3'd2;
  localparam logic [EV_BITS-1:0] EV_EXPIRED     = 3'd3;
  localparam logic [EV_BITS-1:0] EV_LOOKUP      = 3'd4;
  localparam logic [EV_BITS-1:0] EV_RETIRE_DONE = 3'd5;
  localparam logic [EV_BITS-1:0] EV_EXPIRE_DONE = 3'd6;
  localparam logic [EV_BITS-1:0] EV_COUNT       = 3'd7;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [KEY_BITS-1:0]  session_key;
    logic [TIME_BITS-1:0] now_time;
  } req_item_t;

  typedef struct packed {
    logic [EV_BITS-1:0]    event_res;
    logic [KEY_BITS-1:0]   entry_key;
    logic                  present;
    logic                  retired;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  last;
  } rsp_item_t;

endpackage

`default_nettype wire

// ===== rtl/stla_cmp.sv =====
// ----------------------------------------------------------------------------
// stla_cmp: shared add-and-compare unit
// Forms base + addend without overflow and tells whether it is below bound.
// Serves both the age search (addend zero) and the expiry test.
// ----------------------------------------------------------------------------
`default_nettype none

module stla_cmp (
  input  wire logic [stla_pkg::TIME_BITS-1:0]  base,
  input  wire logic [stla_pkg::LIMIT_BITS-1:0] addend,
  input  wire logic [stla_pkg::TIME_BITS-1:0]  bound,
  output logic                                 less
);

  localparam int SUM_W = ((stla_pkg::TIME_BITS > stla_pkg::LIMIT_BITS) ?
                          stla_pkg::TIME_BITS : stla_pkg::LIMIT_BITS) + 1;

  logic [SUM_W-1:0] sum;

  // Widen, add and compare
  always_comb begin
    sum  = SUM_W'(base) + SUM_W'(addend);
    less = sum < SUM_W'(bound);
  end

endmodule

`default_nettype wire

// ===== rtl/session_table_lru_aging.sv =====
// ----------------------------------------------------------------------------
// session_table_lru_aging: session table with LRU eviction and aging
// Keyed table of live sessions; acquire, lookup, retire, expire and count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_item) takes one operation per
//   transaction; the block then works on it alone and drops req_ready.
//   Response channel (rsp_valid/rsp_ready/rsp_item) delivers one or more
//   results per request with a defined operation code; the final one carries last = 1.
//   Each request but count walks the table one slot per cycle, unless a
//   stalled receiver holds it, through one shared key/time memory read
//   port and one shared add-and-compare unit. Count goes straight to its
//   result; an acquire miss on a full table evicts the oldest entry, walks
//   again while still full, then inserts; each result waits for a free response register.
//   A single response register parts the channels: a new request can be
//   taken while the last result still waits for rsp_ready; a stalled
//   receiver holds the walk at the slot that has a result to report.
//   Reset (rst, synchronous) empties the table at once and restores
//   capacity 16 and inactivity limit 60000. Configuration writes through
//   cfg_wr_en/cfg_index/cfg_wr_data take effect on the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module session_table_lru_aging #(
  parameter int SLOTS = stla_pkg::SLOTS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 req_valid,
  output logic                                      req_ready,
  input  wire stla_pkg::req_item_t                  req_item,
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_ready,
  output stla_pkg::rsp_item_t                       rsp_item,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [stla_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [stla_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > stla_pkg::CAP_BITS) ? CNT_W : stla_pkg::CAP_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_EVICT  = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  // Control state
  logic [2:0]                          state;
  logic [SLOT_W-1:0]                   idx;
  logic [CNT_W-1:0]                    count;
  logic [SLOTS-1:0]                    valid;
  logic [SLOTS-1:0]                    retired;
  logic                                match_found;
  logic                                free_found;
  logic                                old_found;
  logic [stla_pkg::CAP_BITS-1:0]       capacity;
  logic [stla_pkg::LIMIT_BITS-1:0]     limit;

  // Request and search payload
  logic [stla_pkg::OP_BITS-1:0]        op_q;
  logic [stla_pkg::KEY_BITS-1:0]       key_q;
  logic [stla_pkg::TIME_BITS-1:0]      now_q;
  logic [SLOT_W-1:0]                   match_slot;
  logic [SLOT_W-1:0]                   free_slot;
  logic [SLOT_W-1:0]                   old_slot;
  logic [stla_pkg::TIME_BITS-1:0]      old_time;
  logic [stla_pkg::KEY_BITS-1:0]       old_key;

  // Key/time memory
  logic [stla_pkg::KEY_BITS-1:0]       key_mem  [SLOTS];
  logic [stla_pkg::TIME_BITS-1:0]      time_mem [SLOTS];
  logic [stla_pkg::KEY_BITS-1:0]       rd_key;
  logic [stla_pkg::TIME_BITS-1:0]      rd_time;
  logic [SLOT_W-1:0]                   rd_addr;
  logic                                mem_we;
  logic [SLOT_W-1:0]                   mem_wa;

  // Strobes and derived values
  logic                                req_accept;
  logic                                out_free;
  logic                                in_scan;
  logic                                slot_valid;
  logic                                key_hit;
  logic                                match_any;
  logic                                is_expire;
  logic                                cmp_less;
  logic [stla_pkg::LIMIT_BITS-1:0]     cmp_addend;
  logic [stla_pkg::TIME_BITS-1:0]      cmp_bound;
  logic [stla_pkg::LIMIT_BITS-1:0]     limit_eff;
  logic [CMP_W-1:0]                    cap_eff;
  logic [CNT_W-1:0]                    count_dec;
  logic [CNT_W-1:0]                    count_inc;
  logic                                full_now;
  logic                                full_after;
  logic                                exp_hit;
  logic                                emit_exp;
  logic                                scan_adv;
  logic                                scan_end;
  logic                                do_evict;
  logic                                do_insert;
  logic                                do_fin;
  logic                                rsp_load;
  stla_pkg::rsp_item_t                 rsp_d;

  assign req_ready  = (state == S_IDLE);
  assign req_accept = req_valid && req_ready;
  assign out_free   = !rsp_valid || rsp_ready;
  assign in_scan    = (state == S_SCAN);
  assign is_expire  = (op_q == stla_pkg::OP_EXPIRE);

  // Clamp the registers to their working range
  always_comb begin
    cap_eff = CMP_W'(capacity);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(SLOTS)) begin
      cap_eff = CMP_W'(SLOTS);
    end
    limit_eff = (limit == '0) ? stla_pkg::LIMIT_BITS'(1) : limit;
  end

  assign count_dec  = count - CNT_W'(1);
  assign count_inc  = count + CNT_W'(1);
  assign full_now   = CMP_W'(count) >= cap_eff;
  assign full_after = CMP_W'(count_dec) >= cap_eff;

  // Shared compare: expiry test or age search
  assign cmp_addend = is_expire ? limit_eff : '0;
  assign cmp_bound  = is_expire ? now_q : old_time;

  stla_cmp u_cmp (
    .base   (rd_time),
    .addend (cmp_addend),
    .bound  (cmp_bound),
    .less   (cmp_less)
  );

  // Per-slot decisions during the walk
  assign slot_valid = valid[idx];
  assign key_hit    = slot_valid && (rd_key == key_q) && !is_expire;
  assign match_any  = match_found || key_hit;
  assign exp_hit    = in_scan && is_expire && slot_valid && cmp_less;
  assign emit_exp   = exp_hit && out_free;
  assign scan_adv   = in_scan && (!exp_hit || out_free);
  assign scan_end   = scan_adv && (idx == LAST_SLOT);
  assign do_evict   = (state == S_EVICT) && out_free;
  assign do_insert  = (state == S_INSERT) && out_free;
  assign do_fin     = (state == S_FIN) && out_free;
  assign rsp_load   = emit_exp || do_evict || do_insert || do_fin;

  // Memory port control: read ahead one slot while walking
  always_comb begin
    rd_addr = '0;
    if (in_scan) begin
      rd_addr = scan_adv ? SLOT_W'(idx + SLOT_W'(1)) : idx;
    end
    mem_we = do_insert || (do_fin && (op_q == stla_pkg::OP_ACQUIRE));
    mem_wa = do_insert ? free_slot : match_slot;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa]  <= key_q;
      time_mem[mem_wa] <= now_q;
    end
    rd_key  <= key_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  // Build the next result
  always_comb begin
    rsp_d = '0;
    if (emit_exp) begin
      rsp_d.event_res   = stla_pkg::EV_EXPIRED;
      rsp_d.entry_key   = rd_key;
      rsp_d.retired     = retired[idx];
      rsp_d.entry_count = stla_pkg::COUNT_BITS'(count_dec);
    end else if (do_evict) begin
      rsp_d.event_res   = stla_pkg::EV_EVICTED;
      rsp_d.entry_key   = old_key;
      rsp_d.retired     = retired[old_slot];
      rsp_d.entry_count = stla_pkg::COUNT_BITS'(count_dec);
    end else if (do_insert) begin
      rsp_d.event_res   = stla_pkg::EV_INSERTED;
      rsp_d.entry_key   = key_q;
      rsp_d.entry_count = stla_pkg::COUNT_BITS'(count_inc);
      rsp_d.last        = 1'b1;
    end else begin
      rsp_d.entry_count = stla_pkg::COUNT_BITS'(count);
      rsp_d.last        = 1'b1;
      case (op_q)
        stla_pkg::OP_ACQUIRE: begin
          rsp_d.event_res = stla_pkg::EV_HIT;
          rsp_d.entry_key = key_q;
          rsp_d.present   = 1'b1;
          rsp_d.retired   = retired[match_slot];
        end
        stla_pkg::OP_LOOKUP: begin
          rsp_d.event_res = stla_pkg::EV_LOOKUP;
          rsp_d.entry_key = key_q;
          rsp_d.present   = match_found;
          rsp_d.retired   = match_found && retired[match_slot];
        end
        stla_pkg::OP_RETIRE: begin
          rsp_d.event_res = stla_pkg::EV_RETIRE_DONE;
          rsp_d.entry_key = key_q;
          rsp_d.present   = match_found;
          rsp_d.retired   = match_found;
        end
        stla_pkg::OP_EXPIRE: begin
          rsp_d.event_res = stla_pkg::EV_EXPIRE_DONE;
        end
        default: begin
          rsp_d.event_res = stla_pkg::EV_COUNT;
        end
      endcase
    end
  end

  // Sequencer, table flags, count, registers and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      count       <= '0;
      valid       <= '0;
      retired     <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      old_found   <= 1'b0;
      capacity    <= stla_pkg::CAPACITY_RESET;
      limit       <= stla_pkg::LIMIT_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_wr_en) begin
        case (cfg_index)
          stla_pkg::REG_CAPACITY: capacity <= cfg_wr_data[stla_pkg::CAP_BITS-1:0];
          stla_pkg::REG_LIMIT:    limit    <= cfg_wr_data[stla_pkg::LIMIT_BITS-1:0];
          default: ;
        endcase
      end

      // Response register
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_accept) begin
            idx         <= '0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            old_found   <= 1'b0;
            case (req_item.operation)
              stla_pkg::OP_ACQUIRE, stla_pkg::OP_LOOKUP,
              stla_pkg::OP_RETIRE, stla_pkg::OP_EXPIRE: state <= S_SCAN;
              stla_pkg::OP_COUNT: state <= S_FIN;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_adv) begin
            idx <= SLOT_W'(idx + SLOT_W'(1));
            if (key_hit) begin
              match_found <= 1'b1;
            end
            if (!slot_valid) begin
              free_found <= 1'b1;
            end
            if (slot_valid && !is_expire) begin
              old_found <= 1'b1;
            end
          end
          // Drop an expired entry
          if (emit_exp) begin
            valid[idx]   <= 1'b0;
            retired[idx] <= 1'b0;
            count        <= count_dec;
          end
          if (scan_end) begin
            if ((op_q == stla_pkg::OP_ACQUIRE) && !match_any) begin
              state <= full_now ? S_EVICT : S_INSERT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_EVICT: begin
          if (do_evict) begin
            valid[old_slot]   <= 1'b0;
            retired[old_slot] <= 1'b0;
            count             <= count_dec;
            free_found        <= 1'b1;
            if (full_after) begin
              // Walk again for the next oldest entry
              idx       <= '0;
              old_found <= 1'b0;
              state     <= S_SCAN;
            end else begin
              state <= S_INSERT;
            end
          end
        end
        S_INSERT: begin
          if (do_insert) begin
            valid[free_slot]   <= 1'b1;
            retired[free_slot] <= 1'b0;
            count              <= count_inc;
            state              <= S_IDLE;
          end
        end
        S_FIN: begin
          if (do_fin) begin
            if ((op_q == stla_pkg::OP_RETIRE) && match_found) begin
              retired[match_slot] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture, search results and response payload
  always_ff @(posedge clk) begin
    if (req_accept) begin
      op_q  <= req_item.operation;
      key_q <= req_item.session_key;
      now_q <= req_item.now_time;
    end
    if (scan_adv) begin
      if (key_hit && !match_found) begin
        match_slot <= idx;
      end
      if (!slot_valid && !free_found) begin
        free_slot <= idx;
      end
      // Strictly older wins, so ties keep the lowest slot
      if (slot_valid && !is_expire && (!old_found || cmp_less)) begin
        old_slot <= idx;
        old_time <= rd_time;
        old_key  <= rd_key;
      end
    end
    // The evicted slot becomes the lowest free one if it is below the rest
    if (do_evict && (!free_found || (old_slot < free_slot))) begin
      free_slot <= old_slot;
    end
    if (rsp_load) begin
      rsp_item <= rsp_d;
    end
  end

  // Checks
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid)))
    else $error("live count disagrees with valid bits");

  a_retired_only_live: assert property (@(posedge clk) disable iff (rst)
    (retired & ~valid) == '0)
    else $error("retired mark on an empty slot");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && rsp_d.last) |=> (state == S_IDLE))
    else $error("final result issued while the item is still in work");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req_ready)
    else $error("request taken while an item is in work");

endmodule

`default_nettype wire
